// File: hw/rtl/wavhp_pkg.sv
package wavhp_pkg;

    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_SIZE_PLAIN = 32'd16;
    localparam logic [31:0] FMT_SIZE_EXT   = 32'd18;
    localparam logic [31:0] FMT_SIZE_WAVEX = 32'd40;

    localparam logic [15:0] SEG_LEN_RESET = 16'd1024;

    // fmt body byte offsets at which a field's last byte arrives
    localparam logic [5:0] POS_FORMAT    = 6'd1;
    localparam logic [5:0] POS_CHANNELS  = 6'd3;
    localparam logic [5:0] POS_RATE      = 6'd7;
    localparam logic [5:0] POS_BYTE_RATE = 6'd11;
    localparam logic [5:0] POS_ALIGN     = 6'd13;
    localparam logic [5:0] POS_BITS      = 6'd15;
    localparam logic [5:0] POS_WORD_LAST = 6'd3;

    typedef enum logic [3:0] {
        PH_RIFF_ID,
        PH_RIFF_SIZE,
        PH_WAVE_ID,
        PH_FMT_ID,
        PH_FMT_SIZE,
        PH_FMT_BODY,
        PH_DATA_ID,
        PH_DATA_SIZE,
        PH_SAMPLES,
        PH_ERROR
    } t_phase;

    typedef enum logic [3:0] {
        OP_CAP_RIFF,
        OP_CAP_FORMAT,
        OP_CAP_CHANNELS,
        OP_CAP_RATE,
        OP_CAP_BYTE_RATE,
        OP_CAP_ALIGN,
        OP_CAP_BITS,
        OP_EMIT_HEADER,
        OP_EMIT_ERROR,
        OP_EMIT_SAMPLE
    } t_op_kind;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_RIFF,
        ERR_WAVE,
        ERR_FMT_ID,
        ERR_FMT_SIZE,
        ERR_DATA_ID
    } t_err;

    typedef enum logic [1:0] {
        RK_HEADER,
        RK_ERROR,
        RK_SAMPLE
    } t_result_kind;

    typedef struct packed {
        t_op_kind    kind;
        t_err        err;
        logic [31:0] word;
    } t_op;

endpackage

// File: hw/rtl/wavhp_front.sv
module wavhp_front
    import wavhp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_restart,
    output logic       o_op_valid,
    output t_op        o_op
);

    t_phase      r_phase, n_phase;
    logic [5:0]  r_pos, n_pos;
    logic [31:0] r_word, n_word;
    logic [5:0]  r_fmt_len, n_fmt_len;

    t_phase      eff_phase;
    logic [5:0]  eff_pos;
    logic [31:0] eff_word;
    logic [5:0]  eff_fmt_len;
    logic [31:0] asm_word;
    logic        word_done;
    logic        body_end;
    logic        size_ok;

    // restart clears the parse before this byte is taken
    assign eff_phase   = i_restart ? PH_RIFF_ID : r_phase;
    assign eff_pos     = i_restart ? 6'd0 : r_pos;
    assign eff_word    = i_restart ? 32'd0 : r_word;
    assign eff_fmt_len = i_restart ? 6'd0 : r_fmt_len;

    assign asm_word  = {i_data_byte, eff_word[31:8]};
    assign word_done = (eff_pos >= POS_WORD_LAST);
    assign body_end  = ({1'b0, eff_pos} + 7'd1) >= {1'b0, eff_fmt_len};
    assign size_ok   = (asm_word == FMT_SIZE_PLAIN) || (asm_word == FMT_SIZE_EXT) ||
                       (asm_word == FMT_SIZE_WAVEX);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            n_phase = eff_phase;
            unique case (eff_phase)
                PH_RIFF_ID: begin
                    if (word_done) n_phase = (asm_word == ID_RIFF) ? PH_RIFF_SIZE : PH_ERROR;
                end
                PH_RIFF_SIZE: begin
                    if (word_done) n_phase = PH_WAVE_ID;
                end
                PH_WAVE_ID: begin
                    if (word_done) n_phase = (asm_word == ID_WAVE) ? PH_FMT_ID : PH_ERROR;
                end
                PH_FMT_ID: begin
                    if (word_done) n_phase = (asm_word == ID_FMT) ? PH_FMT_SIZE : PH_ERROR;
                end
                PH_FMT_SIZE: begin
                    if (word_done) n_phase = size_ok ? PH_FMT_BODY : PH_ERROR;
                end
                PH_FMT_BODY: begin
                    if (body_end) n_phase = PH_DATA_ID;
                end
                PH_DATA_ID: begin
                    if (word_done) n_phase = (asm_word == ID_DATA) ? PH_DATA_SIZE : PH_ERROR;
                end
                PH_DATA_SIZE: begin
                    if (word_done) n_phase = PH_SAMPLES;
                end
                PH_SAMPLES: begin
                    n_phase = PH_SAMPLES;
                end
                PH_ERROR: begin
                    n_phase = PH_ERROR;
                end
                default: begin
                    n_phase = PH_ERROR;
                end
            endcase
        end
    end

    // datapath state and op to the back end
    always_comb begin
        n_pos       = r_pos;
        n_word      = r_word;
        n_fmt_len   = r_fmt_len;
        o_op_valid  = 1'b0;
        o_op.kind   = OP_CAP_RIFF;
        o_op.err    = ERR_NONE;
        o_op.word   = asm_word;
        if (i_accept) begin
            n_pos     = eff_pos;
            n_word    = eff_word;
            n_fmt_len = eff_fmt_len;
            if (eff_phase != PH_ERROR) begin
                n_word = asm_word;
                n_pos  = word_done ? 6'd0 : eff_pos + 6'd1;
            end
            unique case (eff_phase)
                PH_RIFF_ID: begin
                    if (word_done && asm_word != ID_RIFF) begin
                        o_op_valid = 1'b1;
                        o_op.kind  = OP_EMIT_ERROR;
                        o_op.err   = ERR_RIFF;
                    end
                end
                PH_RIFF_SIZE: begin
                    if (word_done) begin
                        o_op_valid = 1'b1;
                        o_op.kind  = OP_CAP_RIFF;
                    end
                end
                PH_WAVE_ID: begin
                    if (word_done && asm_word != ID_WAVE) begin
                        o_op_valid = 1'b1;
                        o_op.kind  = OP_EMIT_ERROR;
                        o_op.err   = ERR_WAVE;
                    end
                end
                PH_FMT_ID: begin
                    if (word_done && asm_word != ID_FMT) begin
                        o_op_valid = 1'b1;
                        o_op.kind  = OP_EMIT_ERROR;
                        o_op.err   = ERR_FMT_ID;
                    end
                end
                PH_FMT_SIZE: begin
                    if (word_done) begin
                        if (size_ok) begin
                            n_fmt_len = asm_word[5:0];
                        end else begin
                            o_op_valid = 1'b1;
                            o_op.kind  = OP_EMIT_ERROR;
                            o_op.err   = ERR_FMT_SIZE;
                        end
                    end
                end
                PH_FMT_BODY: begin
                    n_pos      = body_end ? 6'd0 : eff_pos + 6'd1;
                    o_op_valid = 1'b1;
                    if (eff_pos == POS_FORMAT)         o_op.kind = OP_CAP_FORMAT;
                    else if (eff_pos == POS_CHANNELS)  o_op.kind = OP_CAP_CHANNELS;
                    else if (eff_pos == POS_RATE)      o_op.kind = OP_CAP_RATE;
                    else if (eff_pos == POS_BYTE_RATE) o_op.kind = OP_CAP_BYTE_RATE;
                    else if (eff_pos == POS_ALIGN)     o_op.kind = OP_CAP_ALIGN;
                    else if (eff_pos == POS_BITS)      o_op.kind = OP_CAP_BITS;
                    else                               o_op_valid = 1'b0;
                end
                PH_DATA_ID: begin
                    if (word_done && asm_word != ID_DATA) begin
                        o_op_valid = 1'b1;
                        o_op.kind  = OP_EMIT_ERROR;
                        o_op.err   = ERR_DATA_ID;
                    end
                end
                PH_DATA_SIZE: begin
                    if (word_done) begin
                        o_op_valid = 1'b1;
                        o_op.kind  = OP_EMIT_HEADER;
                    end
                end
                PH_SAMPLES: begin
                    if (word_done) begin
                        o_op_valid = 1'b1;
                        o_op.kind  = OP_EMIT_SAMPLE;
                    end
                end
                PH_ERROR: begin
                    o_op_valid = 1'b0;
                end
                default: begin
                    // corrupt phase code: word is shifted, position kept
                    n_pos = eff_pos;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_RIFF_ID;
            r_pos     <= 6'd0;
            r_word    <= 32'd0;
            r_fmt_len <= 6'd0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_word    <= n_word;
            r_fmt_len <= n_fmt_len;
        end
    end

endmodule

// File: hw/rtl/wavhp_op_queue.sv
module wavhp_op_queue
    import wavhp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_take,
    output logic o_valid,
    output t_op  o_op
);

    t_op        r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_take;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_op    = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_take = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_slot[r_wr_ptr] <= i_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= ~r_wr_ptr;
            if (do_take) r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_take};
        end
    end

endmodule

// File: hw/rtl/wavhp_back.sv
module wavhp_back
    import wavhp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_op_valid,
    input  t_op                i_op,
    output logic               o_op_take,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [1:0]         o_result_kind,
    output logic [2:0]         o_error_code,
    output logic [31:0]        o_riff_size,
    output logic [15:0]        o_format_tag,
    output logic [15:0]        o_channel_count,
    output logic [31:0]        o_sample_rate,
    output logic [31:0]        o_byte_rate,
    output logic [15:0]        o_block_align,
    output logic [15:0]        o_sample_bits,
    output logic [31:0]        o_data_size,
    output logic signed [15:0] o_sample_value,
    output logic               o_segment_last
);

    logic [15:0] r_seg_len;
    logic [15:0] r_seg_cnt;
    logic        r_valid;

    logic [31:0] r_cap_riff;
    logic [15:0] r_cap_format;
    logic [15:0] r_cap_channels;
    logic [31:0] r_cap_rate;
    logic [31:0] r_cap_byte_rate;
    logic [15:0] r_cap_align;
    logic [15:0] r_cap_bits;

    logic        emits;
    logic        take;
    logic [16:0] seg_inc;
    logic        seg_last;

    always_comb begin
        case (i_op.kind) inside
            OP_EMIT_HEADER, OP_EMIT_ERROR, OP_EMIT_SAMPLE: emits = 1'b1;
            default:                                       emits = 1'b0;
        endcase
    end

    // the output register frees up in the same cycle it is popped
    assign take      = i_op_valid && (!emits || !r_valid || i_pop);
    assign o_op_take = take;
    assign o_empty   = !r_valid;

    assign seg_inc  = {1'b0, r_seg_cnt} + 17'd1;
    assign seg_last = (seg_inc >= {1'b0, r_seg_len});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_len <= SEG_LEN_RESET;
            r_seg_cnt <= 16'd0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) r_seg_len <= i_cfg_wdata;
            if (take && emits) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
            if (take && i_op.kind == OP_EMIT_HEADER) begin
                r_seg_cnt <= 16'd0;
            end else if (take && i_op.kind == OP_EMIT_SAMPLE) begin
                r_seg_cnt <= seg_last ? 16'd0 : seg_inc[15:0];
            end
        end
    end

    // field captures and result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            unique case (i_op.kind)
                OP_CAP_RIFF:      r_cap_riff      <= i_op.word;
                OP_CAP_FORMAT:    r_cap_format    <= i_op.word[31:16];
                OP_CAP_CHANNELS:  r_cap_channels  <= i_op.word[31:16];
                OP_CAP_RATE:      r_cap_rate      <= i_op.word;
                OP_CAP_BYTE_RATE: r_cap_byte_rate <= i_op.word;
                OP_CAP_ALIGN:     r_cap_align     <= i_op.word[31:16];
                OP_CAP_BITS:      r_cap_bits      <= i_op.word[31:16];
                OP_EMIT_HEADER: begin
                    o_result_kind   <= RK_HEADER;
                    o_error_code    <= ERR_NONE;
                    o_riff_size     <= r_cap_riff;
                    o_format_tag    <= r_cap_format;
                    o_channel_count <= r_cap_channels;
                    o_sample_rate   <= r_cap_rate;
                    o_byte_rate     <= r_cap_byte_rate;
                    o_block_align   <= r_cap_align;
                    o_sample_bits   <= r_cap_bits;
                    o_data_size     <= i_op.word;
                    o_sample_value  <= 16'sd0;
                    o_segment_last  <= 1'b0;
                end
                OP_EMIT_ERROR, OP_EMIT_SAMPLE: begin
                    o_result_kind   <= (i_op.kind == OP_EMIT_ERROR) ? RK_ERROR : RK_SAMPLE;
                    o_error_code    <= i_op.err;
                    o_riff_size     <= 32'd0;
                    o_format_tag    <= 16'd0;
                    o_channel_count <= 16'd0;
                    o_sample_rate   <= 32'd0;
                    o_byte_rate     <= 32'd0;
                    o_block_align   <= 16'd0;
                    o_sample_bits   <= 16'd0;
                    o_data_size     <= 32'd0;
                    o_sample_value  <= (i_op.kind == OP_EMIT_SAMPLE) ?
                                       signed'(i_op.word[15:0]) : 16'sd0;
                    o_segment_last  <= (i_op.kind == OP_EMIT_SAMPLE) && seg_last;
                end
                default: begin
                    o_result_kind <= o_result_kind;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/wav_header_parser_core.sv
// Channel   Direction  Handshake          Payload
// input     in         push / full        i_data_byte[7:0], i_restart
// result    out        empty / pop        o_result_kind .. o_segment_last
// config    in         i_cfg_we (no wait) i_cfg_wdata[15:0] = segment_length
//
// One byte per cycle while full is low; a result reaches the outputs through the op
// queue, then the output register, after the edge that takes its last byte.
// The front holds the parse phase; a two-entry op queue feeds the back end, which
// keeps captured fields, the segment counter and a one-entry output register.
// full rises only when the op queue holds two ops, i.e. results are not popped.
// Reset is synchronous, active low; it sets segment_length to 1024.
module wav_header_parser_core
    import wavhp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_data_byte,
    input  logic               i_restart,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_result_kind,
    output logic [2:0]         o_error_code,
    output logic [31:0]        o_riff_size,
    output logic [15:0]        o_format_tag,
    output logic [15:0]        o_channel_count,
    output logic [31:0]        o_sample_rate,
    output logic [31:0]        o_byte_rate,
    output logic [15:0]        o_block_align,
    output logic [15:0]        o_sample_bits,
    output logic [31:0]        o_data_size,
    output logic signed [15:0] o_sample_value,
    output logic               o_segment_last,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata
);

    logic accept;
    logic front_op_valid;
    t_op  front_op;
    logic q_valid;
    t_op  q_op;
    logic q_take;

    assign accept = push && !full;

    wavhp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_restart   (i_restart),
        .o_op_valid  (front_op_valid),
        .o_op        (front_op)
    );

    wavhp_op_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_op_valid),
        .i_op    (front_op),
        .o_full  (full),
        .i_take  (q_take),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    wavhp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_op_valid      (q_valid),
        .i_op            (q_op),
        .o_op_take       (q_take),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_result_kind   (o_result_kind),
        .o_error_code    (o_error_code),
        .o_riff_size     (o_riff_size),
        .o_format_tag    (o_format_tag),
        .o_channel_count (o_channel_count),
        .o_sample_rate   (o_sample_rate),
        .o_byte_rate     (o_byte_rate),
        .o_block_align   (o_block_align),
        .o_sample_bits   (o_sample_bits),
        .o_data_size     (o_data_size),
        .o_sample_value  (o_sample_value),
        .o_segment_last  (o_segment_last)
    );

endmodule

// File: bench/wav_header_parser_checker.sv
module wav_header_parser_checker
    import wavhp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  logic [7:0]         i_data_byte,
    input  logic               i_restart,
    input  logic               i_empty,
    input  logic               i_pop,
    input  logic [1:0]         i_result_kind,
    input  logic [2:0]         i_error_code,
    input  logic [31:0]        i_riff_size,
    input  logic [15:0]        i_format_tag,
    input  logic [15:0]        i_channel_count,
    input  logic [31:0]        i_sample_rate,
    input  logic [31:0]        i_byte_rate,
    input  logic [15:0]        i_block_align,
    input  logic [15:0]        i_sample_bits,
    input  logic [31:0]        i_data_size,
    input  logic signed [15:0] i_sample_value,
    input  logic               i_segment_last,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_result_kind       kind;
        t_err               err;
        logic [31:0]        riff_size;
        logic [15:0]        format_tag;
        logic [15:0]        channels;
        logic [31:0]        rate;
        logic [31:0]        byte_rate;
        logic [15:0]        align;
        logic [15:0]        bits;
        logic [31:0]        data_size;
        logic signed [15:0] sample_value;
        logic               last;
    } wav_result_t;

    wav_result_t wav_results_due[$];
    int          mismatches = 0;

    // parser image
    t_phase      cur_phase;
    logic [5:0]  byte_pos;
    logic [31:0] shift_word;
    logic [5:0]  fmt_bytes;
    logic [31:0] hdr_riff;
    logic [15:0] hdr_format;
    logic [15:0] hdr_channels;
    logic [31:0] hdr_rate;
    logic [31:0] hdr_byte_rate;
    logic [15:0] hdr_align;
    logic [15:0] hdr_bits;
    logic [15:0] seg_count;
    logic [15:0] seg_len;

    function automatic void restart_parse();
        cur_phase     = PH_RIFF_ID;
        byte_pos      = '0;
        shift_word    = '0;
        fmt_bytes     = '0;
        hdr_riff      = '0;
        hdr_format    = '0;
        hdr_channels  = '0;
        hdr_rate      = '0;
        hdr_byte_rate = '0;
        hdr_align     = '0;
        hdr_bits      = '0;
        seg_count     = '0;
    endfunction

    function automatic bit word_complete();
        if (byte_pos >= POS_WORD_LAST) begin
            byte_pos = '0;
            return 1'b1;
        end
        byte_pos = byte_pos + 6'd1;
        return 1'b0;
    endfunction

    function automatic void flag_error(t_err code);
        wav_result_t r;
        r = '0;
        r.kind = RK_ERROR;
        r.err = code;
        cur_phase = PH_ERROR;
        byte_pos = '0;
        wav_results_due.push_back(r);
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic new_file);
        wav_result_t r;
        r = '0;
        if (new_file)
            restart_parse();
        if (cur_phase == PH_ERROR)
            return;
        shift_word = {b, shift_word[31:8]};
        case (cur_phase)
            PH_RIFF_ID: begin
                if (word_complete()) begin
                    if (shift_word != ID_RIFF) flag_error(ERR_RIFF);
                    else cur_phase = PH_RIFF_SIZE;
                end
            end
            PH_RIFF_SIZE: begin
                if (word_complete()) begin
                    hdr_riff = shift_word;
                    cur_phase = PH_WAVE_ID;
                end
            end
            PH_WAVE_ID: begin
                if (word_complete()) begin
                    if (shift_word != ID_WAVE) flag_error(ERR_WAVE);
                    else cur_phase = PH_FMT_ID;
                end
            end
            PH_FMT_ID: begin
                if (word_complete()) begin
                    if (shift_word != ID_FMT) flag_error(ERR_FMT_ID);
                    else cur_phase = PH_FMT_SIZE;
                end
            end
            PH_FMT_SIZE: begin
                if (word_complete()) begin
                    if (shift_word != FMT_SIZE_PLAIN && shift_word != FMT_SIZE_EXT &&
                        shift_word != FMT_SIZE_WAVEX) begin
                        flag_error(ERR_FMT_SIZE);
                    end else begin
                        fmt_bytes = shift_word[5:0];
                        cur_phase = PH_FMT_BODY;
                    end
                end
            end
            PH_FMT_BODY: begin
                // fields are taken when their last byte has shifted in
                case (byte_pos)
                    POS_FORMAT:    hdr_format    = shift_word[31:16];
                    POS_CHANNELS:  hdr_channels  = shift_word[31:16];
                    POS_RATE:      hdr_rate      = shift_word;
                    POS_BYTE_RATE: hdr_byte_rate = shift_word;
                    POS_ALIGN:     hdr_align     = shift_word[31:16];
                    POS_BITS:      hdr_bits      = shift_word[31:16];
                    default: ;
                endcase
                if ({1'b0, byte_pos} + 7'd1 >= {1'b0, fmt_bytes}) begin
                    byte_pos = '0;
                    cur_phase = PH_DATA_ID;
                end else begin
                    byte_pos = byte_pos + 6'd1;
                end
            end
            PH_DATA_ID: begin
                if (word_complete()) begin
                    if (shift_word != ID_DATA) flag_error(ERR_DATA_ID);
                    else cur_phase = PH_DATA_SIZE;
                end
            end
            PH_DATA_SIZE: begin
                if (word_complete()) begin
                    cur_phase = PH_SAMPLES;
                    seg_count = '0;
                    r.kind = RK_HEADER;
                    r.err = ERR_NONE;
                    r.riff_size = hdr_riff;
                    r.format_tag = hdr_format;
                    r.channels = hdr_channels;
                    r.rate = hdr_rate;
                    r.byte_rate = hdr_byte_rate;
                    r.align = hdr_align;
                    r.bits = hdr_bits;
                    r.data_size = shift_word;
                    wav_results_due.push_back(r);
                end
            end
            PH_SAMPLES: begin
                if (word_complete()) begin
                    r.kind = RK_SAMPLE;
                    r.err = ERR_NONE;
                    r.sample_value = shift_word[15:0];
                    // a zero length acts as one
                    if ({1'b0, seg_count} + 17'd1 >= {1'b0, seg_len}) begin
                        r.last = 1'b1;
                        seg_count = '0;
                    end else begin
                        seg_count = seg_count + 16'd1;
                    end
                    wav_results_due.push_back(r);
                end
            end
            default: cur_phase = PH_ERROR;
        endcase
    endfunction

    function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    function automatic void check_result();
        wav_result_t want;
        int bad;
        if (wav_results_due.size() == 0) begin
            $display("%0t: result_kind expected none got %0d", $time, i_result_kind);
            mismatches++;
            return;
        end
        want = wav_results_due.pop_front();
        bad = 0;
        bad += field_differs("result_kind", 32'(want.kind), 32'(i_result_kind));
        bad += field_differs("error_code", 32'(want.err), 32'(i_error_code));
        bad += field_differs("riff_size", want.riff_size, i_riff_size);
        bad += field_differs("format_tag", 32'(want.format_tag), 32'(i_format_tag));
        bad += field_differs("channel_count", 32'(want.channels), 32'(i_channel_count));
        bad += field_differs("sample_rate", want.rate, i_sample_rate);
        bad += field_differs("byte_rate", want.byte_rate, i_byte_rate);
        bad += field_differs("block_align", 32'(want.align), 32'(i_block_align));
        bad += field_differs("sample_bits", 32'(want.bits), 32'(i_sample_bits));
        bad += field_differs("data_size", want.data_size, i_data_size);
        bad += field_differs("sample_value", 32'(want.sample_value), 32'(i_sample_value));
        bad += field_differs("segment_last", 32'(want.last), 32'(i_segment_last));
        if (bad != 0)
            mismatches++;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seg_len = SEG_LEN_RESET;
            restart_parse();
            wav_results_due.delete();
        end else begin
            if (i_cfg_we)
                seg_len = i_cfg_wdata;
            if (i_pop && !i_empty)
                check_result();
            if (i_push && !i_full)
                parse_byte(i_data_byte, i_restart);
        end
        o_pending <= wav_results_due.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: bench/tb_wav_header_parser_core.sv
module tb_wav_header_parser_core;
    timeunit 1ns;
    timeprecision 1ps;
    import wavhp_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400_000;
    localparam int          ITEMS_PER_PHASE = 16;
    localparam logic [15:0] FMT_PCM      = 16'h0001;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [7:0]         data_byte = '0;
    logic               restart = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic [1:0]         result_kind;
    logic [2:0]         error_code;
    logic [31:0]        riff_size;
    logic [15:0]        format_tag;
    logic [15:0]        channel_count;
    logic [31:0]        sample_rate;
    logic [31:0]        byte_rate;
    logic [15:0]        block_align;
    logic [15:0]        sample_bits;
    logic [31:0]        data_size;
    logic signed [15:0] sample_value;
    logic               segment_last;
    logic               cfg_we = 1'b0;
    logic [15:0]        cfg_wdata = '0;

    int          fail_count;
    int          pending;
    int unsigned cycle_count = 0;
    int          useful_sent = 0;
    bit          idle_on = 1'b1;
    bit          quiet = 1'b0;

    typedef struct packed {
        logic [7:0] b;
        logic       r;
        logic       junk;
    } byte_item_t;

    byte_item_t file_bytes[$];

    wav_header_parser_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_data_byte     (data_byte),
        .i_restart       (restart),
        .empty           (empty),
        .pop             (pop),
        .o_result_kind   (result_kind),
        .o_error_code    (error_code),
        .o_riff_size     (riff_size),
        .o_format_tag    (format_tag),
        .o_channel_count (channel_count),
        .o_sample_rate   (sample_rate),
        .o_byte_rate     (byte_rate),
        .o_block_align   (block_align),
        .o_sample_bits   (sample_bits),
        .o_data_size     (data_size),
        .o_sample_value  (sample_value),
        .o_segment_last  (segment_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    wav_header_parser_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_data_byte     (data_byte),
        .i_restart       (restart),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_result_kind   (result_kind),
        .i_error_code    (error_code),
        .i_riff_size     (riff_size),
        .i_format_tag    (format_tag),
        .i_channel_count (channel_count),
        .i_sample_rate   (sample_rate),
        .i_byte_rate     (byte_rate),
        .i_block_align   (block_align),
        .i_sample_bits   (sample_bits),
        .i_data_size     (data_size),
        .i_sample_value  (sample_value),
        .i_segment_last  (segment_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stall bursts, always ready once quiet
    initial begin : pop_driver
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (stall > 0)
                stall--;
            else if (idle_on && !quiet && $urandom_range(0, 11) == 0)
                stall = $urandom_range(1, 17);
            pop <= (stall == 0);
        end
    end

    function automatic void add_byte(logic [7:0] b, logic r, logic junk);
        byte_item_t it;
        it.b = b;
        it.r = r;
        it.junk = junk;
        file_bytes.push_back(it);
    endfunction

    // little-endian, restart flag on the first byte only
    function automatic void add_le(logic [31:0] v, int n = 4, logic r = 1'b0);
        for (int i = 0; i < n; i++)
            add_byte(v[8*i +: 8], (i == 0) ? r : 1'b0, 1'b0);
    endfunction

    function automatic void add_junk();
        repeat ($urandom_range(0, 6)) add_byte(8'($urandom), 1'b0, 1'b1);
    endfunction

    function automatic bit add_id(logic [31:0] id, bit broken, logic r = 1'b0);
        logic [31:0] w;
        w = id;
        if (broken)
            w = $urandom_range(0, 1) ? (id ^ (32'd1 << $urandom_range(0, 31))) : $urandom;
        add_le(w, 4, r);
        if (broken)
            add_junk();
        return broken;
    endfunction

    // mode 0 random fields, 1 all zero, 2 all ones
    function automatic logic [31:0] pick_field(int mode);
        if (mode == 1) return '0;
        if (mode == 2) return '1;
        return $urandom;
    endfunction

    function automatic void add_file(t_err fault, int frames, int mode, int fmt_sel);
        logic [31:0] w;
        logic [15:0] s;
        int fmt_len;
        if (add_id(ID_RIFF, fault == ERR_RIFF, 1'b1)) return;
        add_le(pick_field(mode));
        if (add_id(ID_WAVE, fault == ERR_WAVE)) return;
        if (add_id(ID_FMT, fault == ERR_FMT_ID)) return;
        fmt_len = fmt_sel;
        if (fmt_len == 0) begin
            case ($urandom_range(0, 2))
                0: fmt_len = FMT_SIZE_PLAIN;
                1: fmt_len = FMT_SIZE_EXT;
                default: fmt_len = FMT_SIZE_WAVEX;
            endcase
        end
        if (fault == ERR_FMT_SIZE) begin
            w = $urandom_range(0, 1) ? 32'($urandom_range(0, 63)) : $urandom;
            if (w == FMT_SIZE_PLAIN || w == FMT_SIZE_EXT || w == FMT_SIZE_WAVEX)
                w = w + 32'd1;
            add_le(w);
            add_junk();
            return;
        end
        add_le(fmt_len);
        w = (mode == 0 && $urandom_range(0, 3) != 0) ? 32'(FMT_PCM) : pick_field(mode);
        add_le(w, 2);
        add_le(pick_field(mode), 2);
        add_le(pick_field(mode));
        add_le(pick_field(mode));
        add_le(pick_field(mode), 2);
        add_le(pick_field(mode), 2);
        repeat (fmt_len - 16) add_byte(8'($urandom), 1'b0, 1'b0);
        if (add_id(ID_DATA, fault == ERR_DATA_ID)) return;
        add_le(pick_field(mode));
        for (int i = 0; i < frames; i++) begin
            if (mode != 0) begin
                case (i % 4)
                    0: s = 16'h8000;
                    1: s = 16'h7FFF;
                    2: s = 16'h0000;
                    default: s = 16'hFFFF;
                endcase
            end else begin
                s = 16'($urandom);
            end
            add_le(32'(s), 2);
            add_le($urandom, 2);
        end
    endfunction

    function automatic void truncate_to(int n);
        while (file_bytes.size() > n)
            void'(file_bytes.pop_back());
    endfunction

    task automatic send_item(logic [7:0] b, logic r);
        push <= 1'b1;
        data_byte <= b;
        restart <= r;
        do @(posedge i_clk); while (full);
        if (idle_on && !quiet && $urandom_range(0, 9) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic send_file_bytes();
        byte_item_t it;
        while (file_bytes.size() > 0) begin
            it = file_bytes.pop_front();
            send_item(it.b, it.r);
            if (!it.junk)
                useful_sent++;
        end
    endtask

    task automatic drain_results();
        push <= 1'b0;
        repeat (4) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_seg_len(logic [15:0] v);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        logic [15:0] seg_settings[6];
        int target;
        int base;
        int pick;
        seg_settings = '{16'd1, 16'd0, 16'd65535, 16'd3, 16'd1024, 16'd1024};
        seg_settings[4] = 16'($urandom_range(2, 9));
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: each fmt size, field extremes, every error, restart mid-header
        add_file(ERR_NONE, 4, 2, FMT_SIZE_PLAIN);
        add_file(ERR_NONE, 4, 1, FMT_SIZE_EXT);
        add_file(ERR_NONE, 2, 0, FMT_SIZE_WAVEX);
        for (int e = 1; e <= 5; e++)
            add_file(t_err'(e), 0, 0, 0);
        base = file_bytes.size();
        add_file(ERR_NONE, 0, 0, FMT_SIZE_PLAIN);
        truncate_to(base + 30);
        add_file(ERR_NONE, 3, 0, 0);
        send_file_bytes();

        for (int k = 0; k < 6; k++) begin
            write_seg_len(seg_settings[k]);
            quiet = (k == 5);
            target = useful_sent + ITEMS_PER_PHASE;
            while (useful_sent < target) begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    add_file(ERR_NONE, $urandom_range(0, 10), 0, 0);
                else
                    add_file(t_err'($urandom_range(1, 5)), 0, 0, 0);
                // this file may be cut short, so the next restart lands in the middle of it
                if ($urandom_range(0, 6) == 0)
                    truncate_to($urandom_range(1, file_bytes.size()));
                send_file_bytes();
                idle_on = ($urandom_range(0, 4) != 0);
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
